### rtl/gamepad_velocity_command_controller_assert.svh
// Assertion macros for the gamepad velocity command controller.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GAMEPAD_VELOCITY_COMMAND_CONTROLLER_ASSERT_SVH
`define GAMEPAD_VELOCITY_COMMAND_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define GVCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GVCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gvcc_pkg.sv
// Shared types and constants for the gamepad velocity command controller.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package gvcc_pkg;

    // Field widths
    localparam int AXIS_W  = 16;
    localparam int VEL_W   = 16;
    localparam int CAP_W   = 15;
    localparam int FRAC_W  = 16;
    localparam int LVL_W   = 2;
    localparam int BTN_N   = 5;
    localparam int PROD_W  = AXIS_W + CAP_W;
    localparam int MULB_W  = FRAC_W + 1;
    localparam int WIDE_W  = PROD_W + MULB_W;

    // Configuration port
    localparam int DATA_W    = 32;
    localparam int REG_N     = 8;
    localparam int REG_IDX_W = $clog2(REG_N);
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_LIN_CAP_SLOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIN_CAP_MEDIUM = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIN_CAP_FAST   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ANG_CAP_SLOW   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ANG_CAP_MEDIUM = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ANG_CAP_FAST   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LIN_INC_FRAC   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ANG_INC_FRAC   = 3'd7;

    localparam logic [CAP_W-1:0]  CAP_SLOW_RST   = 15'd8192;
    localparam logic [CAP_W-1:0]  CAP_MEDIUM_RST = 15'd16384;
    localparam logic [CAP_W-1:0]  CAP_FAST_RST   = 15'd32767;
    localparam logic [FRAC_W-1:0] INC_FRAC_RST   = 16'd6554;

    // Cap level codes; the fourth code is never reached from reset
    localparam logic [LVL_W-1:0] LVL_SLOW   = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MEDIUM = 2'd1;
    localparam logic [LVL_W-1:0] LVL_FAST   = 2'd2;

    typedef struct packed {
        logic [CAP_W-1:0]  lin_cap_slow;
        logic [CAP_W-1:0]  lin_cap_medium;
        logic [CAP_W-1:0]  lin_cap_fast;
        logic [CAP_W-1:0]  ang_cap_slow;
        logic [CAP_W-1:0]  ang_cap_medium;
        logic [CAP_W-1:0]  ang_cap_fast;
        logic [FRAC_W-1:0] lin_increment_frac;
        logic [FRAC_W-1:0] ang_increment_frac;
    } t_cfg;

    typedef struct packed {
        logic signed [AXIS_W-1:0] axis_lin_absolute;
        logic signed [AXIS_W-1:0] axis_lin_rate;
        logic signed [AXIS_W-1:0] axis_ang_absolute;
        logic signed [AXIS_W-1:0] axis_ang_rate;
        logic                     soft_brake_btn;
        logic                     hard_brake_btn;
        logic                     lock_btn;
        logic                     lin_cap_btn;
        logic                     ang_cap_btn;
        logic                     lin_mode_btn;
        logic                     ang_mode_btn;
    } t_sample;

    typedef struct packed {
        logic signed [VEL_W-1:0] linear_velocity;
        logic signed [VEL_W-1:0] angular_velocity;
        logic                    locked_out;
        logic                    braking_out;
        logic                    motor_enable_pulse;
        logic                    motor_disable_pulse;
        logic [LVL_W-1:0]        lin_cap_level;
        logic [LVL_W-1:0]        ang_cap_level;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;     // take the sample, run the button logic
        logic mul_ax;   // axis times cap
        logic mul_fr;   // product times increment fraction
        logic fin;      // round, accumulate, clip, write velocity
        logic chan;     // 0 linear, 1 angular
        logic publish;  // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic update;   // unlocked and not braking
        logic out_free; // output register can take a result
    } t_status;

endpackage

`default_nettype wire

### rtl/gvcc_if.sv
// Handshake channels of the gamepad velocity command controller.
// Depends on gvcc_pkg for field widths.
`default_nettype none

interface gvcc_sample_if;
    import gvcc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] axis_lin_absolute;
    logic signed [AXIS_W-1:0] axis_lin_rate;
    logic signed [AXIS_W-1:0] axis_ang_absolute;
    logic signed [AXIS_W-1:0] axis_ang_rate;
    logic                     soft_brake_btn;
    logic                     hard_brake_btn;
    logic                     lock_btn;
    logic                     lin_cap_btn;
    logic                     ang_cap_btn;
    logic                     lin_mode_btn;
    logic                     ang_mode_btn;

    modport source (
        output valid, axis_lin_absolute, axis_lin_rate, axis_ang_absolute, axis_ang_rate,
        output soft_brake_btn, hard_brake_btn, lock_btn, lin_cap_btn, ang_cap_btn,
        output lin_mode_btn, ang_mode_btn,
        input  ready
    );

    modport sink (
        input  valid, axis_lin_absolute, axis_lin_rate, axis_ang_absolute, axis_ang_rate,
        input  soft_brake_btn, hard_brake_btn, lock_btn, lin_cap_btn, ang_cap_btn,
        input  lin_mode_btn, ang_mode_btn,
        output ready
    );
endinterface

interface gvcc_command_if;
    import gvcc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] linear_velocity;
    logic signed [VEL_W-1:0] angular_velocity;
    logic                    locked_out;
    logic                    braking_out;
    logic                    motor_enable_pulse;
    logic                    motor_disable_pulse;
    logic [LVL_W-1:0]        lin_cap_level;
    logic [LVL_W-1:0]        ang_cap_level;

    modport source (
        output valid, linear_velocity, angular_velocity, locked_out, braking_out,
        output motor_enable_pulse, motor_disable_pulse, lin_cap_level, ang_cap_level,
        input  ready
    );

    modport sink (
        input  valid, linear_velocity, angular_velocity, locked_out, braking_out,
        input  motor_enable_pulse, motor_disable_pulse, lin_cap_level, ang_cap_level,
        output ready
    );
endinterface

`default_nettype wire

### rtl/gamepad_velocity_command_controller.sv
// Gamepad velocity command controller.
//
// Usage:
//   i_sample  : one gamepad sample per item (four Q1.15 stick axes, seven
//               button levels). Taken when valid and ready are both high.
//   o_command : one velocity command per sample (linear and angular velocity,
//               lock and brake flags, enable/disable pulses, cap levels).
//   APB port  : eight configuration registers at byte addresses 4*i; write only
//               while the block is idle. pready is tied high.
// Sequence:
//   An item that drives the velocities steps through an axis product, a fraction
//   product and a finish step for each channel, then the publish state; an item
//   that finds the block locked or braking goes from the linear axis product
//   straight to publish. The steps follow from the single shared multiplier,
//   used twice per channel, plus a finish step per channel.
// Reset (synchronous, active low): velocities zero, locked, not braking, slow
//   caps, absolute mode, all buttons treated as released; registers return to
//   their reset values.
// Stall: the command waits in the output register while ready is low; a new
//   sample is still taken and processed, then held until that register frees.
// Depends on gvcc_pkg, gvcc_if, gvcc_regs, gvcc_ctrl and gvcc_dp.
`default_nettype none

module gamepad_velocity_command_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gvcc_sample_if.sink                   i_sample,
    gvcc_command_if.source                o_command,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gvcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [gvcc_pkg::DATA_W-1:0]   pwdata,
    output logic [gvcc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import gvcc_pkg::*;

    t_cfg    w_cfg;
    t_sample w_sample;
    t_result w_result;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_out_valid;

    // Register bank: caps per level and the increment fractions
    gvcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Pack the sample channel into one payload word
    assign w_sample.axis_lin_absolute = i_sample.axis_lin_absolute;
    assign w_sample.axis_lin_rate     = i_sample.axis_lin_rate;
    assign w_sample.axis_ang_absolute = i_sample.axis_ang_absolute;
    assign w_sample.axis_ang_rate     = i_sample.axis_ang_rate;
    assign w_sample.soft_brake_btn    = i_sample.soft_brake_btn;
    assign w_sample.hard_brake_btn    = i_sample.hard_brake_btn;
    assign w_sample.lock_btn          = i_sample.lock_btn;
    assign w_sample.lin_cap_btn       = i_sample.lin_cap_btn;
    assign w_sample.ang_cap_btn       = i_sample.ang_cap_btn;
    assign w_sample.lin_mode_btn      = i_sample.lin_mode_btn;
    assign w_sample.ang_mode_btn      = i_sample.ang_mode_btn;
    assign i_sample.ready             = w_in_ready;

    // Sequencer: ready only between items
    gvcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: flags, shared multiplier and output register
    gvcc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_sample    (w_sample),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_command.ready),
        .o_out       (w_result)
    );

    // Unpack the output register onto the command channel
    assign o_command.valid               = w_out_valid;
    assign o_command.linear_velocity     = w_result.linear_velocity;
    assign o_command.angular_velocity    = w_result.angular_velocity;
    assign o_command.locked_out          = w_result.locked_out;
    assign o_command.braking_out         = w_result.braking_out;
    assign o_command.motor_enable_pulse  = w_result.motor_enable_pulse;
    assign o_command.motor_disable_pulse = w_result.motor_disable_pulse;
    assign o_command.lin_cap_level       = w_result.lin_cap_level;
    assign o_command.ang_cap_level       = w_result.ang_cap_level;

endmodule

`default_nettype wire

### rtl/gvcc_regs.sv
// Configuration register bank with an APB-style write and read port.
// Depends on gvcc_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module gvcc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gvcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [gvcc_pkg::DATA_W-1:0]   pwdata,
    output logic [gvcc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output gvcc_pkg::t_cfg                o_cfg
);
    import gvcc_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_LIN_CAP_SLOW:   n_cfg.lin_cap_slow       = pwdata[CAP_W-1:0];
                REG_LIN_CAP_MEDIUM: n_cfg.lin_cap_medium     = pwdata[CAP_W-1:0];
                REG_LIN_CAP_FAST:   n_cfg.lin_cap_fast       = pwdata[CAP_W-1:0];
                REG_ANG_CAP_SLOW:   n_cfg.ang_cap_slow       = pwdata[CAP_W-1:0];
                REG_ANG_CAP_MEDIUM: n_cfg.ang_cap_medium     = pwdata[CAP_W-1:0];
                REG_ANG_CAP_FAST:   n_cfg.ang_cap_fast       = pwdata[CAP_W-1:0];
                REG_LIN_INC_FRAC:   n_cfg.lin_increment_frac = pwdata[FRAC_W-1:0];
                REG_ANG_INC_FRAC:   n_cfg.ang_increment_frac = pwdata[FRAC_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LIN_CAP_SLOW:   prdata = DATA_W'(r_cfg.lin_cap_slow);
            REG_LIN_CAP_MEDIUM: prdata = DATA_W'(r_cfg.lin_cap_medium);
            REG_LIN_CAP_FAST:   prdata = DATA_W'(r_cfg.lin_cap_fast);
            REG_ANG_CAP_SLOW:   prdata = DATA_W'(r_cfg.ang_cap_slow);
            REG_ANG_CAP_MEDIUM: prdata = DATA_W'(r_cfg.ang_cap_medium);
            REG_ANG_CAP_FAST:   prdata = DATA_W'(r_cfg.ang_cap_fast);
            REG_LIN_INC_FRAC:   prdata = DATA_W'(r_cfg.lin_increment_frac);
            REG_ANG_INC_FRAC:   prdata = DATA_W'(r_cfg.ang_increment_frac);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lin_cap_slow       <= CAP_SLOW_RST;
            r_cfg.lin_cap_medium     <= CAP_MEDIUM_RST;
            r_cfg.lin_cap_fast       <= CAP_FAST_RST;
            r_cfg.ang_cap_slow       <= CAP_SLOW_RST;
            r_cfg.ang_cap_medium     <= CAP_MEDIUM_RST;
            r_cfg.ang_cap_fast       <= CAP_FAST_RST;
            r_cfg.lin_increment_frac <= INC_FRAC_RST;
            r_cfg.ang_increment_frac <= INC_FRAC_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### rtl/gvcc_ctrl.sv
// Sequencer for one gamepad sample: button logic, then two products and a finish step
// per channel on the shared multiplier, or straight to publish when locked or braking. Depends on gvcc_pkg.
`default_nettype none
`include "gamepad_velocity_command_controller_assert.svh"

module gvcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gvcc_pkg::t_status i_status,
    output gvcc_pkg::t_cmd    o_cmd
);
    import gvcc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIN_AX,
        S_LIN_FR,
        S_LIN_FIN,
        S_ANG_AX,
        S_ANG_FR,
        S_ANG_FIN,
        S_PUBLISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LIN_AX;
                end
            end
            S_LIN_AX: begin
                o_cmd.mul_ax = 1'b1;
                // skip the arithmetic when locked or braking
                n_state = i_status.update ? S_LIN_FR : S_PUBLISH;
            end
            S_LIN_FR: begin
                o_cmd.mul_fr = 1'b1;
                n_state      = S_LIN_FIN;
            end
            S_LIN_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_ANG_AX;
            end
            S_ANG_AX: begin
                o_cmd.mul_ax = 1'b1;
                o_cmd.chan   = 1'b1;
                n_state      = S_ANG_FR;
            end
            S_ANG_FR: begin
                o_cmd.mul_fr = 1'b1;
                o_cmd.chan   = 1'b1;
                n_state      = S_ANG_FIN;
            end
            S_ANG_FIN: begin
                o_cmd.fin  = 1'b1;
                o_cmd.chan = 1'b1;
                n_state    = S_PUBLISH;
            end
            S_PUBLISH: begin
                // hold until the output register has room
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `GVCC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == S_LIN_AX, "accept did not start")
    `GVCC_ASSERT_IMPLY(a_fin_needs_update, i_clk, i_rst_n, o_cmd.fin, i_status.update, "finish while held")
    `GVCC_ASSERT_IMPLY(a_publish_has_room, i_clk, i_rst_n, o_cmd.publish, i_status.out_free, "output overrun")

endmodule

`default_nettype wire

### rtl/gvcc_dp.sv
// Datapath: button edge logic, control flags, shared multiplier, rounding,
// accumulation with clipping, and the output register. Depends on gvcc_pkg.
`default_nettype none
`include "gamepad_velocity_command_controller_assert.svh"

module gvcc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gvcc_pkg::t_cfg    i_cfg,
    input  gvcc_pkg::t_sample i_sample,
    input  gvcc_pkg::t_cmd    i_cmd,
    output gvcc_pkg::t_status o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gvcc_pkg::t_result o_out
);
    import gvcc_pkg::*;

    function automatic logic [LVL_W-1:0] next_level(input logic [LVL_W-1:0] lv);
        logic [LVL_W-1:0] nl;
        case (lv)
            LVL_SLOW:   nl = LVL_MEDIUM;
            LVL_MEDIUM: nl = LVL_FAST;
            LVL_FAST:   nl = LVL_SLOW;
            default:    nl = lv;
        endcase
        return nl;
    endfunction

    // Control state
    logic signed [VEL_W-1:0] r_lin_vel, n_lin_vel;
    logic signed [VEL_W-1:0] r_ang_vel, n_ang_vel;
    logic                    r_lock, n_lock;
    logic                    r_brake, n_brake;
    logic [LVL_W-1:0]        r_lin_level, n_lin_level;
    logic [LVL_W-1:0]        r_ang_level, n_ang_level;
    logic                    r_lin_incr, n_lin_incr;
    logic                    r_ang_incr, n_ang_incr;
    logic [BTN_N-1:0]        r_released, n_released;
    logic                    r_en, n_en;
    logic                    r_dis, n_dis;
    logic                    r_out_valid, n_out_valid;

    // Payload
    logic signed [AXIS_W-1:0] r_ax_lin, n_ax_lin;
    logic signed [AXIS_W-1:0] r_ax_ang, n_ax_ang;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [WIDE_W-1:0] r_wide, n_wide;
    t_result                  r_out, n_out;

    logic [BTN_N-1:0]         w_levels;
    logic [BTN_N-1:0]         w_press;
    logic [CAP_W-1:0]         w_lin_cap;
    logic [CAP_W-1:0]         w_ang_cap;
    logic [CAP_W-1:0]         w_cap;
    logic [FRAC_W-1:0]        w_frac;
    logic signed [AXIS_W-1:0] w_ax;
    logic signed [VEL_W-1:0]  w_old;
    logic                     w_incr;
    logic signed [PROD_W-1:0] w_mul_a;
    logic signed [MULB_W-1:0] w_mul_b;
    logic signed [WIDE_W-1:0] w_mul_p;
    logic signed [PROD_W:0]   w_abs_sum;
    logic signed [WIDE_W-1:0] w_inc_sum;
    logic signed [VEL_W+1:0]  w_nv;
    logic signed [VEL_W+1:0]  w_cap_x;
    logic signed [VEL_W-1:0]  w_fin_v;
    logic signed [VEL_W:0]    w_lin_vel_x, w_lin_cap_x;
    logic signed [VEL_W:0]    w_ang_vel_x, w_ang_cap_x;

    // Cap by level; the unreachable fourth level selects zero
    always_comb begin
        case (r_lin_level)
            LVL_SLOW:   w_lin_cap = i_cfg.lin_cap_slow;
            LVL_MEDIUM: w_lin_cap = i_cfg.lin_cap_medium;
            LVL_FAST:   w_lin_cap = i_cfg.lin_cap_fast;
            default:    w_lin_cap = '0;
        endcase
        case (r_ang_level)
            LVL_SLOW:   w_ang_cap = i_cfg.ang_cap_slow;
            LVL_MEDIUM: w_ang_cap = i_cfg.ang_cap_medium;
            LVL_FAST:   w_ang_cap = i_cfg.ang_cap_fast;
            default:    w_ang_cap = '0;
        endcase
    end

    assign w_cap  = i_cmd.chan ? w_ang_cap : w_lin_cap;
    assign w_frac = i_cmd.chan ? i_cfg.ang_increment_frac : i_cfg.lin_increment_frac;
    assign w_ax   = i_cmd.chan ? r_ax_ang : r_ax_lin;
    assign w_old  = i_cmd.chan ? r_ang_vel : r_lin_vel;
    assign w_incr = i_cmd.chan ? r_ang_incr : r_lin_incr;

    // Shared multiplier: axis x cap, then product x fraction
    assign w_mul_a = i_cmd.mul_fr ? r_prod : {{(PROD_W-AXIS_W){w_ax[AXIS_W-1]}}, w_ax};
    assign w_mul_b = i_cmd.mul_fr ? {1'b0, w_frac} : {{(MULB_W-CAP_W){1'b0}}, w_cap};
    assign w_mul_p = w_mul_a * w_mul_b;

    // Round half up; in rate mode also accumulate and clip to the cap
    assign w_abs_sum = {r_prod[PROD_W-1], r_prod} + (PROD_W+1)'(1 << (CAP_W - 1));
    assign w_inc_sum = r_wide + (WIDE_W'(1) << (2 * CAP_W));
    assign w_nv      = {{2{w_old[VEL_W-1]}}, w_old}
                     + (VEL_W+2)'($signed(w_inc_sum[WIDE_W-1:2*CAP_W+1]));
    assign w_cap_x   = {3'b000, w_cap};

    always_comb begin
        if (!w_incr) begin
            w_fin_v = w_abs_sum[CAP_W +: VEL_W];
        end else if (w_nv > w_cap_x) begin
            w_fin_v = VEL_W'(w_cap_x);
        end else if (w_nv < -w_cap_x) begin
            w_fin_v = VEL_W'(-w_cap_x);
        end else begin
            w_fin_v = w_nv[VEL_W-1:0];
        end
    end

    assign w_levels = {i_sample.ang_mode_btn, i_sample.lin_mode_btn, i_sample.ang_cap_btn,
                       i_sample.lin_cap_btn, i_sample.lock_btn};
    assign w_press  = r_released & w_levels;

    always_comb begin
        n_lin_vel   = r_lin_vel;
        n_ang_vel   = r_ang_vel;
        n_lock      = r_lock;
        n_brake     = r_brake;
        n_lin_level = r_lin_level;
        n_ang_level = r_ang_level;
        n_lin_incr  = r_lin_incr;
        n_ang_incr  = r_ang_incr;
        n_released  = r_released;
        n_en        = r_en;
        n_dis       = r_dis;
        n_ax_lin    = r_ax_lin;
        n_ax_ang    = r_ax_ang;
        n_prod      = r_prod;
        n_wide      = r_wide;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_cmd.load) begin
            n_en  = 1'b0;
            n_dis = 1'b0;
            if (i_sample.soft_brake_btn || i_sample.hard_brake_btn) begin
                if (!r_brake) begin
                    n_brake   = 1'b1;
                    n_lin_vel = '0;
                    n_ang_vel = '0;
                end
            end else begin
                n_brake = 1'b0;
            end
            if (i_sample.hard_brake_btn && !r_lock) begin
                n_dis  = 1'b1;
                n_lock = 1'b1;
            end
            if (w_press[0]) begin
                if (n_lock) begin
                    n_lock = 1'b0;
                    n_en   = 1'b1;
                end else begin
                    n_lin_vel = '0;
                    n_ang_vel = '0;
                    n_dis     = 1'b1;
                    n_lock    = 1'b1;
                    n_brake   = 1'b0;
                end
            end
            if (w_press[1]) n_lin_level = next_level(r_lin_level);
            if (w_press[2]) n_ang_level = next_level(r_ang_level);
            if (w_press[3]) n_lin_incr  = !r_lin_incr;
            if (w_press[4]) n_ang_incr  = !r_ang_incr;
            n_released = ~w_levels;
            // keep only the stick that the new mode reads
            n_ax_lin = n_lin_incr ? i_sample.axis_lin_rate : i_sample.axis_lin_absolute;
            n_ax_ang = n_ang_incr ? i_sample.axis_ang_rate : i_sample.axis_ang_absolute;
        end

        if (i_cmd.mul_ax) n_prod = w_mul_p[PROD_W-1:0];
        if (i_cmd.mul_fr) n_wide = w_mul_p;

        if (i_cmd.fin) begin
            if (i_cmd.chan) begin
                n_ang_vel = w_fin_v;
            end else begin
                n_lin_vel = w_fin_v;
            end
        end

        if (i_cmd.publish) begin
            n_out_valid               = 1'b1;
            n_out.linear_velocity     = r_lin_vel;
            n_out.angular_velocity    = r_ang_vel;
            n_out.locked_out          = r_lock;
            n_out.braking_out         = r_brake;
            n_out.motor_enable_pulse  = r_en;
            n_out.motor_disable_pulse = r_dis;
            n_out.lin_cap_level       = r_lin_level;
            n_out.ang_cap_level       = r_ang_level;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_vel   <= '0;
            r_ang_vel   <= '0;
            r_lock      <= 1'b1;
            r_brake     <= 1'b0;
            r_lin_level <= LVL_SLOW;
            r_ang_level <= LVL_SLOW;
            r_lin_incr  <= 1'b0;
            r_ang_incr  <= 1'b0;
            r_released  <= '1;
            r_en        <= 1'b0;
            r_dis       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_lin_vel   <= n_lin_vel;
            r_ang_vel   <= n_ang_vel;
            r_lock      <= n_lock;
            r_brake     <= n_brake;
            r_lin_level <= n_lin_level;
            r_ang_level <= n_ang_level;
            r_lin_incr  <= n_lin_incr;
            r_ang_incr  <= n_ang_incr;
            r_released  <= n_released;
            r_en        <= n_en;
            r_dis       <= n_dis;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax_lin <= n_ax_lin;
        r_ax_ang <= n_ax_ang;
        r_prod   <= n_prod;
        r_wide   <= n_wide;
        r_out    <= n_out;
    end

    assign o_status.update   = !r_lock && !r_brake;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    assign w_lin_vel_x = {r_lin_vel[VEL_W-1], r_lin_vel};
    assign w_ang_vel_x = {r_ang_vel[VEL_W-1], r_ang_vel};
    assign w_lin_cap_x = {2'b00, w_lin_cap};
    assign w_ang_cap_x = {2'b00, w_ang_cap};

    `GVCC_ASSERT_IMPLY(a_enable_unlocks, i_clk, i_rst_n, r_out_valid && r_out.motor_enable_pulse, !r_out.locked_out, "enable while locked")
    `GVCC_ASSERT_NEXT(a_lin_within_cap, i_clk, i_rst_n, i_cmd.fin && !i_cmd.chan, w_lin_vel_x <= w_lin_cap_x && w_lin_vel_x >= -w_lin_cap_x, "linear beyond cap")
    `GVCC_ASSERT_NEXT(a_ang_within_cap, i_clk, i_rst_n, i_cmd.fin && i_cmd.chan, w_ang_vel_x <= w_ang_cap_x && w_ang_vel_x >= -w_ang_cap_x, "angular beyond cap")

endmodule

`default_nettype wire
